[rtl/stable_givens_rotation_core_defines.svh]
// Assertion macros shared by the checker of the Givens rotation core.
// Needs a clk and an active-high rst in the scope where a macro is used.
`ifndef STABLE_GIVENS_ROTATION_CORE_DEFINES_SVH
`define STABLE_GIVENS_ROTATION_CORE_DEFINES_SVH

// Property that must hold at every edge out of reset.
`define SGR_ASSERT_ALWAYS(label, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("sgr check failed");

// Implication checked at every edge out of reset.
`define SGR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgr check failed");

`endif

[rtl/sgr_pkg.sv]
`timescale 1ns / 1ps
// Shared constants and types of the stable Givens rotation core.
// No dependencies.
package sgr_pkg;

  localparam int DEF_IN_WIDTH  = 32;
  localparam int DEF_COEF_FRAC = 30;

  // Per-item flags that travel beside the arithmetic pipeline.
  typedef struct packed {
    logic valid;
    logic neg_a;
    logic neg_b;
    logic zero_a;
    logic zero_b;
  } sgr_side_t;

endpackage

[rtl/sgr_div_cell.sv]
`timescale 1ns / 1ps
// One restoring division step: produces one quotient bit per cycle.
// Standalone; chained by the top level.
module sgr_div_cell #(
  parameter int REM_W = 64,
  parameter int QW    = 63
) (
  input  logic             clk,
  input  logic [REM_W-1:0] den_in,
  input  logic [REM_W-1:0] rem_in,
  input  logic [QW-1:0]    q_in,
  output logic [REM_W-1:0] den_out,
  output logic [REM_W-1:0] rem_out,
  output logic [QW-1:0]    q_out
);

  logic [REM_W:0] rem_sh;
  logic [REM_W:0] diff;
  logic           ge;

  always_comb begin
    rem_sh = {rem_in, 1'b0};
    diff   = rem_sh - {1'b0, den_in};
    ge     = (rem_sh >= {1'b0, den_in});
  end

  always_ff @(posedge clk) begin
    den_out <= den_in;
    rem_out <= ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
    q_out   <= {q_in[QW-2:0], ge};
  end

endmodule

[rtl/sgr_sqrt_cell.sv]
`timescale 1ns / 1ps
// One digit-by-digit square root step: one root bit per cycle.
// Standalone; chained by the top level.
module sgr_sqrt_cell #(
  parameter int R = 32
) (
  input  logic           clk,
  input  logic [2*R-1:0] rad_in,
  input  logic [R+1:0]   rem_in,
  input  logic [R-1:0]   root_in,
  output logic [2*R-1:0] rad_out,
  output logic [R+1:0]   rem_out,
  output logic [R-1:0]   root_out
);

  logic [R+1:0] rem_sh;
  logic [R+1:0] trial;
  logic         ge;

  always_comb begin
    // bring down the next two radicand bits
    rem_sh = {rem_in[R-1:0], rad_in[2*R-1 -: 2]};
    trial  = {root_in, 2'b01};
    ge     = (rem_sh >= trial);
  end

  always_ff @(posedge clk) begin
    rad_out  <= {rad_in[2*R-3:0], 2'b00};
    rem_out  <= ge ? (rem_sh - trial) : rem_sh;
    root_out <= {root_in[R-2:0], ge};
  end

endmodule

[rtl/sgr_delay.sv]
`timescale 1ns / 1ps
// Fixed delay line that aligns the shorter arithmetic chain with the longer.
// Standalone.
module sgr_delay #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] din,
  output logic [WIDTH-1:0] dout
);

  generate
    if (DEPTH == 0) begin : g_none
      assign dout = din;
    end else begin : g_line
      logic [WIDTH-1:0] taps [0:DEPTH-1];
      always_ff @(posedge clk) begin
        taps[0] <= din;
        for (int i = 1; i < DEPTH; i++) begin
          taps[i] <= taps[i-1];
        end
      end
      assign dout = taps[DEPTH-1];
    end
  endgenerate

endmodule

[rtl/stable_givens_rotation_core.sv]
`timescale 1ns / 1ps
// Stable Givens rotation core: from (a, b) gives cosine, sine and norm with
// cosine = a/r, sine = b/r, norm = r, r = sqrt(a^2 + b^2), each rounded to nearest.
// Channels: an item (a_value, b_value, signed Q.16) is taken at an edge where start
// is high; busy stays low, so one item may enter every cycle.
// Results come out in order, one per item, on cosine/sine (signed Q1.COEF_FRAC) and
// norm (unsigned Q.16), each shown for one cycle with done high.
// The path is a chain of cells, one bit per cell: 2*COEF_FRAC + 2 division cells
// and COEF_FRAC + 2 square root cells for the coefficients, IN_WIDTH + 1 square root
// cells for the norm, all run side by side; the longer chain sets the latency.
// Throughput: one item per cycle.
// Reset clears all valid flags; items in flight are dropped and done is low after it.
// The receiver cannot stall, so nothing ever holds back the pipeline.
// Depends on sgr_pkg, sgr_div_cell, sgr_sqrt_cell and sgr_delay.
module stable_givens_rotation_core
  import sgr_pkg::*;
#(
  parameter int IN_WIDTH  = DEF_IN_WIDTH,
  parameter int COEF_FRAC = DEF_COEF_FRAC
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [IN_WIDTH-1:0]  a_value,
  input  logic signed [IN_WIDTH-1:0]  b_value,
  output logic                        done,
  output logic signed [COEF_FRAC+1:0] cosine,
  output logic signed [COEF_FRAC+1:0] sine,
  output logic [IN_WIDTH-1:0]         norm
);

  localparam int W2 = 2 * IN_WIDTH;
  localparam int QW = 2 * COEF_FRAC + 3;
  localparam int D  = 2 * COEF_FRAC + 2;
  localparam int RC = COEF_FRAC + 2;
  localparam int RN = IN_WIDTH + 1;
  localparam int LC = D + RC;
  localparam int LT = (LC > RN) ? LC : RN;
  localparam int PL = 3 + LT;

  assign busy = 1'b0;

  sgr_side_t side [0:PL-1];
  sgr_side_t side_next;

  logic [IN_WIDTH-1:0] mag_a, mag_b, mag_a_next, mag_b_next;
  logic [W2-1:0]       sq_a, sq_b;
  logic [W2-1:0]       den, rem_a0, rem_b0;
  logic [QW-1:0]       q_a0, q_b0;

  always_comb begin
    mag_a_next        = a_value[IN_WIDTH-1] ? (~a_value + 1'b1) : a_value;
    mag_b_next        = b_value[IN_WIDTH-1] ? (~b_value + 1'b1) : b_value;
    side_next.valid   = start;
    side_next.neg_a   = a_value[IN_WIDTH-1];
    side_next.neg_b   = b_value[IN_WIDTH-1];
    side_next.zero_a  = (a_value == '0);
    side_next.zero_b  = (b_value == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PL; i++) begin
        side[i] <= '0;
      end
    end else begin
      side[0] <= side_next;
      for (int i = 1; i < PL; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  // operand stages: magnitudes, squares, sum of squares
  always_ff @(posedge clk) begin
    mag_a  <= mag_a_next;
    mag_b  <= mag_b_next;
    sq_a   <= W2'(mag_a) * W2'(mag_a);
    sq_b   <= W2'(mag_b) * W2'(mag_b);
    den    <= sq_a + sq_b;
    // a^2 >= N only when b is zero; then the integer quotient bit is one
    rem_a0 <= side[1].zero_b ? '0 : sq_a;
    rem_b0 <= side[1].zero_a ? '0 : sq_b;
    q_a0   <= QW'(side[1].zero_b);
    q_b0   <= QW'(side[1].zero_a);
  end

  // division chains: q = floor(x^2 * 2^(2F+2) / N)
  wire [W2-1:0] den_a [0:D];
  wire [W2-1:0] den_b [0:D];
  wire [W2-1:0] rem_a [0:D];
  wire [W2-1:0] rem_b [0:D];
  wire [QW-1:0] q_a   [0:D];
  wire [QW-1:0] q_b   [0:D];

  assign den_a[0] = den;
  assign den_b[0] = den;
  assign rem_a[0] = rem_a0;
  assign rem_b[0] = rem_b0;
  assign q_a[0]   = q_a0;
  assign q_b[0]   = q_b0;

  generate
    for (genvar k = 0; k < D; k++) begin : g_div
      sgr_div_cell #(.REM_W(W2), .QW(QW)) u_div_a (
        .clk(clk), .den_in(den_a[k]), .rem_in(rem_a[k]), .q_in(q_a[k]),
        .den_out(den_a[k+1]), .rem_out(rem_a[k+1]), .q_out(q_a[k+1])
      );
      sgr_div_cell #(.REM_W(W2), .QW(QW)) u_div_b (
        .clk(clk), .den_in(den_b[k]), .rem_in(rem_b[k]), .q_in(q_b[k]),
        .den_out(den_b[k+1]), .rem_out(rem_b[k+1]), .q_out(q_b[k+1])
      );
    end
  endgenerate

  // coefficient roots: t = floor(sqrt(q))
  wire [2*RC-1:0] crad_a [0:RC];
  wire [2*RC-1:0] crad_b [0:RC];
  wire [RC+1:0]   crem_a [0:RC];
  wire [RC+1:0]   crem_b [0:RC];
  wire [RC-1:0]   croot_a [0:RC];
  wire [RC-1:0]   croot_b [0:RC];

  assign crad_a[0]  = {1'b0, q_a[D]};
  assign crad_b[0]  = {1'b0, q_b[D]};
  assign crem_a[0]  = '0;
  assign crem_b[0]  = '0;
  assign croot_a[0] = '0;
  assign croot_b[0] = '0;

  generate
    for (genvar k = 0; k < RC; k++) begin : g_csqrt
      sgr_sqrt_cell #(.R(RC)) u_sqrt_a (
        .clk(clk), .rad_in(crad_a[k]), .rem_in(crem_a[k]), .root_in(croot_a[k]),
        .rad_out(crad_a[k+1]), .rem_out(crem_a[k+1]), .root_out(croot_a[k+1])
      );
      sgr_sqrt_cell #(.R(RC)) u_sqrt_b (
        .clk(clk), .rad_in(crad_b[k]), .rem_in(crem_b[k]), .root_in(croot_b[k]),
        .rad_out(crad_b[k+1]), .rem_out(crem_b[k+1]), .root_out(croot_b[k+1])
      );
    end
  endgenerate

  // norm root: t = floor(sqrt(4N))
  wire [2*RN-1:0] nrad  [0:RN];
  wire [RN+1:0]   nrem  [0:RN];
  wire [RN-1:0]   nroot [0:RN];

  assign nrad[0]  = {den, 2'b00};
  assign nrem[0]  = '0;
  assign nroot[0] = '0;

  generate
    for (genvar k = 0; k < RN; k++) begin : g_nsqrt
      sgr_sqrt_cell #(.R(RN)) u_sqrt_n (
        .clk(clk), .rad_in(nrad[k]), .rem_in(nrem[k]), .root_in(nroot[k]),
        .rad_out(nrad[k+1]), .rem_out(nrem[k+1]), .root_out(nroot[k+1])
      );
    end
  endgenerate

  logic [RC-1:0] tc_a, tc_b;
  logic [RN-1:0] tn;

  sgr_delay #(.WIDTH(2 * RC), .DEPTH(LT - LC)) u_cdelay (
    .clk(clk), .din({croot_a[RC], croot_b[RC]}), .dout({tc_a, tc_b})
  );

  sgr_delay #(.WIDTH(RN), .DEPTH(LT - RN)) u_ndelay (
    .clk(clk), .din(nroot[RN]), .dout(tn)
  );

  // round half up: m = (t + 1) >> 1
  logic [RC:0]         ma_sum, mb_sum;
  logic [RN:0]         mn_sum;
  logic [RC-1:0]       ma, mb;
  logic [RC-1:0]       cos_next, sin_next;
  logic [IN_WIDTH-1:0] norm_next;
  sgr_side_t           fin;

  always_comb begin
    fin    = side[PL-1];
    ma_sum = {1'b0, tc_a} + 1'b1;
    mb_sum = {1'b0, tc_b} + 1'b1;
    mn_sum = {1'b0, tn} + 1'b1;
    ma     = ma_sum[RC:1];
    mb     = mb_sum[RC:1];
    if (fin.zero_a && fin.zero_b) begin
      cos_next  = RC'(1) << COEF_FRAC;
      sin_next  = '0;
      norm_next = '0;
    end else begin
      cos_next  = fin.neg_a ? (~ma + 1'b1) : ma;
      sin_next  = fin.neg_b ? (~mb + 1'b1) : mb;
      norm_next = mn_sum[IN_WIDTH:1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= fin.valid;
    end
  end

  always_ff @(posedge clk) begin
    cosine <= cos_next;
    sine   <= sin_next;
    norm   <= norm_next;
  end

endmodule

[rtl/sgr_checker.sv]
`timescale 1ns / 1ps
// Port-level checks of the stable Givens rotation core, bound to the top level.
// Depends on sgr_pkg and stable_givens_rotation_core_defines.svh.
`include "stable_givens_rotation_core_defines.svh"
module sgr_checker
  import sgr_pkg::*;
#(
  parameter int IN_WIDTH  = DEF_IN_WIDTH,
  parameter int COEF_FRAC = DEF_COEF_FRAC
) (
  input logic                        clk,
  input logic                        rst,
  input logic                        start,
  input logic                        busy,
  input logic signed [IN_WIDTH-1:0]  a_value,
  input logic signed [IN_WIDTH-1:0]  b_value,
  input logic                        done,
  input logic signed [COEF_FRAC+1:0] cosine,
  input logic signed [COEF_FRAC+1:0] sine,
  input logic [IN_WIDTH-1:0]         norm
);

  localparam logic signed [COEF_FRAC+1:0] ONE = (COEF_FRAC + 2)'(1) << COEF_FRAC;
  localparam logic signed [COEF_FRAC+1:0] NEG_ONE = -ONE;

  `SGR_ASSERT_ALWAYS(a_never_busy, !busy)
  `SGR_ASSERT_IMPLY(a_quiet_after_reset, $past(rst), !done)
  `SGR_ASSERT_IMPLY(a_coef_range, done, cosine <= ONE && cosine >= NEG_ONE && sine <= ONE && sine >= NEG_ONE)
  `SGR_ASSERT_IMPLY(a_zero_pair, done && norm == '0, cosine == ONE && sine == '0)
  `SGR_ASSERT_IMPLY(a_nonzero_coef, done, cosine != '0 || sine != '0)

endmodule

bind stable_givens_rotation_core sgr_checker #(
  .IN_WIDTH(IN_WIDTH),
  .COEF_FRAC(COEF_FRAC)
) u_sgr_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// Self-checking bench for stable_givens_rotation_core: drives (a, b) pairs and checks
// cosine, sine and norm against exactly rounded values worked out with wide integers.
// Depends on the core and its sub-blocks only.
module tb;

  localparam int CLK_HALF  = 10;
  localparam int LATENCY   = 98;
  localparam int N_RANDOM  = 1300;

  typedef struct {
    logic signed [31:0] cos_v;
    logic signed [31:0] sin_v;
    logic [31:0]        norm_v;
  } rotation_t;

  class rotation_board;
    rotation_t pending[$];
    int        errors;

    function new();
      errors = 0;
    endfunction

    // Largest m in [0, hi] with m == 0 or (2m-1)^2 * p <= q4.
    function logic [63:0] nearest_root(logic [191:0] q4, logic [191:0] p, logic [63:0] hi);
      logic [63:0]  lo;
      logic [63:0]  mid;
      logic [191:0] t;
      lo = 0;
      while (lo < hi) begin
        mid = lo + (hi - lo + 1) / 2;
        t = 192'(2 * mid - 1);
        t = t * t * p;
        if (t <= q4) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function rotation_t rotate(logic signed [31:0] a, logic signed [31:0] b);
      rotation_t    r;
      logic [31:0]  xa;
      logic [31:0]  xb;
      logic [191:0] a2;
      logic [191:0] b2;
      logic [191:0] n2;
      logic [63:0]  k;
      xa = a[31] ? (~a + 1) : a;
      xb = b[31] ? (~b + 1) : b;
      if (xa == 0 && xb == 0) begin
        r.cos_v = 32'sd1 <<< 30;
        r.sin_v = 0;
        r.norm_v = 0;
        return r;
      end
      a2 = 192'(xa) * 192'(xa);
      b2 = 192'(xb) * 192'(xb);
      n2 = a2 + b2;
      k = nearest_root(a2 << 62, n2, 64'd1 << 30);
      r.cos_v = a[31] ? -k[31:0] : k[31:0];
      k = nearest_root(b2 << 62, n2, 64'd1 << 30);
      r.sin_v = b[31] ? -k[31:0] : k[31:0];
      k = nearest_root(n2 << 2, 192'd1, 64'hFFFF_FFFF);
      r.norm_v = k[31:0];
      return r;
    endfunction

    function void note_pair(logic signed [31:0] a, logic signed [31:0] b);
      pending.push_back(rotate(a, b));
    endfunction

    function void check_result(logic signed [31:0] c, logic signed [31:0] s, logic [31:0] n);
      rotation_t e;
      if (pending.size() == 0) begin
        $display("%0t: result with nothing pending: cos %h sin %h norm %h", $time, c, s, n);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (c !== e.cos_v) begin
        $display("%0t: cosine expected %h actual %h", $time, e.cos_v, c);
        errors++;
      end
      if (s !== e.sin_v) begin
        $display("%0t: sine expected %h actual %h", $time, e.sin_v, s);
        errors++;
      end
      if (n !== e.norm_v) begin
        $display("%0t: norm expected %h actual %h", $time, e.norm_v, n);
        errors++;
      end
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] a_value;
  logic signed [31:0] b_value;
  logic               done;
  logic signed [31:0] cosine;
  logic signed [31:0] sine;
  logic [31:0]        norm;

  rotation_board board = new();
  bit            calm;

  stable_givens_rotation_core u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_value(a_value), .b_value(b_value),
    .done(done), .cosine(cosine), .sine(sine), .norm(norm)
  );

  always begin
    clk = 1'b0;
    #CLK_HALF;
    clk = 1'b1;
    #CLK_HALF;
  end

  // Note accepted items and check results on pre-edge values.
  always @(posedge clk) begin
    if (!rst && start && !busy) board.note_pair(a_value, b_value);
    if (!rst && done) board.check_result(cosine, sine, norm);
  end

  // Idle after about a quarter of the items, unless calm is set.
  task automatic send_pair(logic signed [31:0] a, logic signed [31:0] b);
    start   <= 1'b1;
    a_value <= a;
    b_value <= b;
    do @(posedge clk); while (busy);
    if (!calm && $urandom_range(99) < 25) begin
      start   <= 1'b0;
      a_value <= $urandom;
      b_value <= $urandom;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  function automatic logic signed [31:0] rand_field();
    case ($urandom_range(5))
      0:       return $signed($urandom_range(255)) - 128;
      1:       return 0;
      2:       return $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    logic signed [31:0] x;
    rst     <= 1'b1;
    start   <= 1'b0;
    a_value <= '0;
    b_value <= '0;
    calm    = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Zeros, signs, extremes and equal magnitudes.
    send_pair(0, 0);
    send_pair(32'sh0001_0000, 0);
    send_pair(-32'sh0001_0000, 0);
    send_pair(0, 32'sh0003_0000);
    send_pair(0, -32'sh0003_0000);
    send_pair(32'sh8000_0000, 0);
    send_pair(0, 32'sh8000_0000);
    send_pair(32'sh8000_0000, 32'sh8000_0000);
    send_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
    send_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
    send_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
    send_pair(1, 1);
    send_pair(-1, 1);
    send_pair(1, -1);
    send_pair(3, 4);
    send_pair(-3, -4);
    send_pair(1, 32'sh7FFF_FFFF);
    send_pair(32'sh7FFF_FFFF, -1);
    send_pair(32'sh8000_0000, 1);
    send_pair(-1, 0);
    send_pair(0, 1);
    send_pair(32'shFFFF_FFFF, 32'shFFFF_FFFF);

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 500 && i < 800);
      case ($urandom_range(4))
        0: begin
          x = $urandom;
          send_pair(x, $urandom_range(1) ? x : -x);
        end
        1:       send_pair(rand_field(), rand_field());
        default: send_pair($urandom, $urandom);
      endcase
    end
    start <= 1'b0;

    while (board.pending.size() != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (board.errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

endmodule
